@@ design/sfha_pkg.sv @@
// ----------------------------------------------------------------------------
// sfha_pkg
// Shared constants, types and helpers of the segregated-fit heap allocator.
// ----------------------------------------------------------------------------
package sfha_pkg;

    localparam int HEAP_WORDS  = 65536;
    localparam int NUM_CLASSES = 12;
    localparam int HEAP_AW     = $clog2(HEAP_WORDS);
    localparam int CLS_W       = $clog2(NUM_CLASSES + 1);
    localparam int PRO_WORDS   = NUM_CLASSES + 2 + (NUM_CLASSES % 2);
    localparam int ROOT_BASE   = 8;
    localparam int FIRST_BP    = (PRO_WORDS + 2) * 4;
    localparam int INIT_TOP    = FIRST_BP + 16;
    localparam logic [32:0] HEAP_BYTES = 33'(HEAP_WORDS) * 33'd4;

    localparam logic [2:0] CMD_MALLOC  = 3'd0;
    localparam logic [2:0] CMD_FREE    = 3'd1;
    localparam logic [2:0] CMD_REALLOC = 3'd2;
    localparam logic [2:0] CMD_READ    = 3'd3;
    localparam logic [2:0] CMD_WRITE   = 3'd4;

    typedef struct packed {
        logic               we;
        logic [HEAP_AW-1:0] waddr;
        logic [31:0]        wdata;
        logic [HEAP_AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic        valid;
        logic [17:0] addr;
        logic [31:0] rdata;
        logic        status;
    } t_result;

    // class i holds sizes up to 16<<i, the last one everything larger
    function automatic logic [CLS_W-1:0] class_of(input logic [31:0] sz);
        logic [CLS_W-1:0] c;
        c = CLS_W'(NUM_CLASSES - 1);
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if ({1'b0, sz} <= (33'd16 << k)) begin
                c = CLS_W'(k);
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] root_of(input logic [CLS_W-1:0] c);
        return 32'(ROOT_BASE) + {{(30-CLS_W){1'b0}}, c, 2'b00};
    endfunction

    // heap image after reset: prologue, roots, one 16 byte free block, epilogue
    function automatic logic [31:0] init_word(input logic [HEAP_AW-1:0] idx);
        logic [31:0] w;
        w = 32'd0;
        if (idx == HEAP_AW'(1) || idx == HEAP_AW'(PRO_WORDS)) begin
            w = 32'(PRO_WORDS * 4 + 1);
        end else if (idx == HEAP_AW'(2)) begin
            w = 32'(FIRST_BP);
        end else if (idx == HEAP_AW'(PRO_WORDS + 1) || idx == HEAP_AW'(PRO_WORDS + 4)) begin
            w = 32'd16;
        end else if (idx == HEAP_AW'(PRO_WORDS + 5)) begin
            w = 32'd1;
        end
        return w;
    endfunction

endpackage

@@ design/sfha_ram.sv @@
// ----------------------------------------------------------------------------
// sfha_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfha_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sfha_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfha_ctrl
// Command sequencer: list walks, tag rewrites, merges and copies on the heap RAM.
// ----------------------------------------------------------------------------
module sfha_ctrl
    import sfha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_cmd,
    input  logic [17:0] i_addr,
    input  logic [17:0] i_size,
    input  logic [31:0] i_wdata,
    output logic        o_idle,
    output t_result     o_res,
    input  logic        i_res_take,
    output t_mem_req    o_mem,
    input  logic [31:0] i_mem_rdata
);

    localparam logic [6:0] S_CLR = 7'd0,  S_IDLE = 7'd1, S_DISP = 7'd2, S_RD1 = 7'd3;
    localparam logic [6:0] S_DONE = 7'd4;
    localparam logic [6:0] S_U0 = 7'd5,  S_U1 = 7'd6,  S_U2 = 7'd7,  S_U3 = 7'd8;
    localparam logic [6:0] S_U4 = 7'd9,  S_U5 = 7'd10;
    localparam logic [6:0] S_L0 = 7'd11, S_L1 = 7'd12, S_L2 = 7'd13, S_L3 = 7'd14;
    localparam logic [6:0] S_L4 = 7'd15;
    localparam logic [6:0] S_M0 = 7'd16, S_M1 = 7'd17, S_M2 = 7'd18, S_M3 = 7'd19;
    localparam logic [6:0] S_M4 = 7'd20, S_M5 = 7'd21, S_M6 = 7'd22, S_MDONE = 7'd23;
    localparam logic [6:0] S_MP2 = 7'd24, S_MP3 = 7'd25, S_MP4 = 7'd26, S_MP5 = 7'd27;
    localparam logic [6:0] S_MP6 = 7'd28;
    localparam logic [6:0] S_MN1 = 7'd29, S_MN2 = 7'd30, S_MN3 = 7'd31, S_MN4 = 7'd32;
    localparam logic [6:0] S_MN6 = 7'd33, S_MN7 = 7'd34, S_MN8 = 7'd35, S_MN9 = 7'd36;
    localparam logic [6:0] S_MN10 = 7'd37;
    localparam logic [6:0] S_MB1 = 7'd38, S_MB2 = 7'd39, S_MB3 = 7'd40, S_MB4 = 7'd41;
    localparam logic [6:0] S_MB5 = 7'd42, S_MB6 = 7'd43, S_MB7 = 7'd44, S_MB8 = 7'd45;
    localparam logic [6:0] S_MB9 = 7'd46, S_MB10 = 7'd47, S_MB11 = 7'd48, S_MB12 = 7'd49;
    localparam logic [6:0] S_MB13 = 7'd50;
    localparam logic [6:0] S_G0 = 7'd51, S_G1 = 7'd52, S_G2 = 7'd53, S_G3 = 7'd54;
    localparam logic [6:0] S_F0 = 7'd55, S_F1 = 7'd56, S_F2 = 7'd57;
    localparam logic [6:0] S_C0 = 7'd58, S_C1 = 7'd59, S_C2 = 7'd60, S_C3 = 7'd61;
    localparam logic [6:0] S_C4 = 7'd62, S_C5 = 7'd63, S_C6 = 7'd64, S_C7 = 7'd65;
    localparam logic [6:0] S_A0 = 7'd66;
    localparam logic [6:0] S_FR0 = 7'd67, S_FR1 = 7'd68, S_FR2 = 7'd69;
    localparam logic [6:0] S_R0 = 7'd70, S_R1 = 7'd71, S_R2 = 7'd72, S_R3 = 7'd73;
    localparam logic [6:0] S_R4 = 7'd74, S_R5 = 7'd75, S_R5B = 7'd76, S_R6 = 7'd77;
    localparam logic [6:0] S_K0 = 7'd78, S_K1 = 7'd79;

    logic [6:0]         r_state, n_state, r_ret_l, n_ret_l, r_ret_m, n_ret_m;
    logic [6:0]         r_ret_a, n_ret_a, r_ret_f, n_ret_f;
    logic [2:0]         r_cmd, n_cmd;
    logic [17:0]        r_addr, n_addr, r_req, n_req;
    logic [31:0]        r_wdata, n_wdata, r_asize, n_asize, r_bp, n_bp, r_lbp, n_lbp;
    logic [31:0]        r_root, n_root, r_succ, n_succ, r_pred, n_pred, r_head, n_head;
    logic [31:0]        r_t, n_t, r_size, n_size, r_cs, n_cs, r_ptr, n_ptr, r_old, n_old;
    logic [31:0]        r_res, n_res, r_rdout, n_rdout;
    logic               r_pa, n_pa, r_na, n_na, r_null, n_null;
    logic [HEAP_AW:0]   r_cnt, n_cnt, r_idx, n_idx, r_steps, n_steps;
    logic [CLS_W-1:0]   r_c, n_c;
    logic [18:0]        r_top, n_top;
    logic [HEAP_AW-1:0] r_clr, n_clr;

    logic [31:0]        tag_rd, a_round, top32, idx4;
    t_mem_req           mem;

    function automatic logic [HEAP_AW-1:0] ix(input logic [31:0] a);
        return a[HEAP_AW+1:2];
    endfunction

    assign tag_rd  = {i_mem_rdata[31:3], 3'b000};
    assign a_round = (r_req <= 18'd8) ? 32'd16 : ((32'(r_req) + 32'd15) & ~32'h7);
    assign top32   = 32'(r_top);
    assign idx4    = {{(31-HEAP_AW-2){1'b0}}, r_idx, 2'b00};

    always_comb begin
        n_state = r_state;  n_ret_l = r_ret_l;  n_ret_m = r_ret_m;  n_ret_a = r_ret_a;
        n_ret_f = r_ret_f;  n_cmd = r_cmd;      n_addr = r_addr;    n_req = r_req;
        n_wdata = r_wdata;  n_asize = r_asize;  n_bp = r_bp;        n_lbp = r_lbp;
        n_root = r_root;    n_succ = r_succ;    n_pred = r_pred;    n_head = r_head;
        n_t = r_t;          n_size = r_size;    n_cs = r_cs;        n_ptr = r_ptr;
        n_old = r_old;      n_res = r_res;      n_rdout = r_rdout;  n_pa = r_pa;
        n_na = r_na;        n_null = r_null;    n_cnt = r_cnt;      n_idx = r_idx;
        n_steps = r_steps;  n_c = r_c;          n_top = r_top;      n_clr = r_clr;
        mem = '0;
        case (r_state)
            S_CLR: begin
                mem.we = 1'b1;  mem.waddr = r_clr;  mem.wdata = init_word(r_clr);
                n_clr = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_cmd;  n_addr = i_addr;  n_req = i_size;  n_wdata = i_wdata;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_res = '0;  n_null = 1'b0;  n_rdout = '0;  n_ptr = 32'(r_addr);
                n_state = S_DONE;
                case (r_cmd)
                    CMD_MALLOC: begin
                        n_ret_a = S_DONE;  n_state = S_A0;
                    end
                    CMD_FREE: begin
                        n_ret_f = S_DONE;  n_state = S_FR0;
                    end
                    CMD_REALLOC: n_state = S_R0;
                    CMD_READ: begin
                        mem.raddr = ix(32'(r_addr));  n_state = S_RD1;
                    end
                    CMD_WRITE: begin
                        mem.we = 1'b1;  mem.waddr = ix(32'(r_addr));  mem.wdata = r_wdata;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RD1: begin
                n_rdout = i_mem_rdata;  n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            // unlink r_lbp from its list
            S_U0: begin
                mem.raddr = ix(r_lbp - 32'd4);  n_state = S_U1;
            end
            S_U1: begin
                n_root = root_of(class_of(tag_rd));
                mem.raddr = ix(r_lbp + 32'd4);  n_state = S_U2;
            end
            S_U2: begin
                n_succ = i_mem_rdata;  mem.raddr = ix(r_root);  n_state = S_U3;
            end
            S_U3: begin
                if (r_lbp == i_mem_rdata) begin
                    mem.we = 1'b1;  mem.waddr = ix(r_root);  mem.wdata = r_succ;
                    n_state = r_ret_l;
                end else begin
                    mem.raddr = ix(r_lbp);  n_state = S_U4;
                end
            end
            S_U4: begin
                n_pred = i_mem_rdata;
                mem.we = 1'b1;  mem.waddr = ix(i_mem_rdata + 32'd4);  mem.wdata = r_succ;
                n_state = (r_succ == '0) ? r_ret_l : S_U5;
            end
            S_U5: begin
                mem.we = 1'b1;  mem.waddr = ix(r_succ);  mem.wdata = r_pred;
                n_state = r_ret_l;
            end
            // push r_lbp on the head of its list
            S_L0: begin
                mem.raddr = ix(r_lbp - 32'd4);  n_state = S_L1;
            end
            S_L1: begin
                n_root = root_of(class_of(tag_rd));
                mem.raddr = ix(root_of(class_of(tag_rd)));  n_state = S_L2;
            end
            S_L2: begin
                n_head = i_mem_rdata;
                mem.we = 1'b1;  mem.waddr = ix(r_lbp + 32'd4);  mem.wdata = i_mem_rdata;
                n_state = S_L3;
            end
            S_L3: begin
                if (r_head != '0) begin
                    mem.we = 1'b1;  mem.waddr = ix(r_head);  mem.wdata = r_lbp;
                end
                n_state = S_L4;
            end
            S_L4: begin
                mem.we = 1'b1;  mem.waddr = ix(r_root);  mem.wdata = r_lbp;
                n_state = r_ret_l;
            end
            // coalesce r_bp with its neighbours
            S_M0: begin
                mem.raddr = ix(r_bp - 32'd8);  n_state = S_M1;
            end
            S_M1: begin
                n_t = r_bp - tag_rd;  mem.raddr = ix(r_bp - tag_rd - 32'd4);  n_state = S_M2;
            end
            S_M2: begin
                mem.raddr = ix(r_t + tag_rd - 32'd8);  n_state = S_M3;
            end
            S_M3: begin
                n_pa = i_mem_rdata[0];  mem.raddr = ix(r_bp - 32'd4);  n_state = S_M4;
            end
            S_M4: begin
                mem.raddr = ix(r_bp + tag_rd - 32'd4);  n_state = S_M5;
            end
            S_M5: begin
                n_na = i_mem_rdata[0];  mem.raddr = ix(r_bp - 32'd4);  n_state = S_M6;
            end
            S_M6: begin
                n_size = tag_rd;
                mem.raddr = ix(r_bp - 32'd8);
                if (r_pa && r_na) begin
                    n_lbp = r_bp;  n_ret_l = S_MDONE;  n_state = S_L0;
                end else if (r_pa) begin
                    n_lbp = r_bp + tag_rd;  n_ret_l = S_MP2;  n_state = S_U0;
                end else if (r_na) begin
                    n_state = S_MN1;
                end else begin
                    n_state = S_MB1;
                end
            end
            S_MDONE: n_state = r_ret_m;
            S_MP2: begin
                mem.raddr = ix(r_bp - 32'd4);  n_state = S_MP3;
            end
            S_MP3: begin
                mem.raddr = ix(r_bp + tag_rd - 32'd4);  n_state = S_MP4;
            end
            S_MP4: begin
                n_size = r_size + tag_rd;
                mem.we = 1'b1;  mem.waddr = ix(r_bp - 32'd4);  mem.wdata = r_size + tag_rd;
                n_state = S_MP5;
            end
            S_MP5: begin
                mem.raddr = ix(r_bp - 32'd4);  n_state = S_MP6;
            end
            S_MP6: begin
                mem.we = 1'b1;  mem.waddr = ix(r_bp + tag_rd - 32'd8);  mem.wdata = r_size;
                n_lbp = r_bp;  n_ret_l = S_MDONE;  n_state = S_L0;
            end
            S_MN1: begin
                n_lbp = r_bp - tag_rd;  n_ret_l = S_MN2;  n_state = S_U0;
            end
            S_MN2: begin
                mem.raddr = ix(r_bp - 32'd8);  n_state = S_MN3;
            end
            S_MN3: begin
                mem.raddr = ix(r_bp - tag_rd - 32'd4);  n_state = S_MN4;
            end
            S_MN4: begin
                n_size = r_size + tag_rd;  mem.raddr = ix(r_bp - 32'd8);  n_state = S_MN6;
            end
            S_MN6: begin
                mem.we = 1'b1;  mem.waddr = ix(r_bp - tag_rd - 32'd4);  mem.wdata = r_size;
                n_state = S_MN7;
            end
            S_MN7: begin
                mem.raddr = ix(r_bp - 32'd4);  n_state = S_MN8;
            end
            S_MN8: begin
                mem.we = 1'b1;  mem.waddr = ix(r_bp + tag_rd - 32'd8);  mem.wdata = r_size;
                n_state = S_MN9;
            end
            S_MN9: begin
                mem.raddr = ix(r_bp - 32'd8);  n_state = S_MN10;
            end
            S_MN10: begin
                n_bp = r_bp - tag_rd;  n_lbp = r_bp - tag_rd;
                n_ret_l = S_MDONE;  n_state = S_L0;
            end
            S_MB1: begin
                n_lbp = r_bp - tag_rd;  n_ret_l = S_MB2;  n_state = S_U0;
            end
            S_MB2: begin
                mem.raddr = ix(r_bp - 32'd4);  n_state = S_MB3;
            end
            S_MB3: begin
                n_lbp = r_bp + tag_rd;  n_ret_l = S_MB4;  n_state = S_U0;
            end
            S_MB4: begin
                mem.raddr = ix(r_bp - 32'd8);  n_state = S_MB5;
            end
            S_MB5: begin
                mem.raddr = ix(r_bp - tag_rd - 32'd4);  n_state = S_MB6;
            end
            S_MB6: begin
                n_size = r_size + tag_rd;  mem.raddr = ix(r_bp - 32'd4);  n_state = S_MB7;
            end
            S_MB7: begin
                n_t = r_bp + tag_rd;  mem.raddr = ix(r_bp + tag_rd - 32'd4);  n_state = S_MB8;
            end
            S_MB8: begin
                mem.raddr = ix(r_t + tag_rd - 32'd8);  n_state = S_MB9;
            end
            S_MB9: begin
                n_size = r_size + tag_rd;  mem.raddr = ix(r_bp - 32'd8);  n_state = S_MB10;
            end
            S_MB10: begin
                mem.we = 1'b1;  mem.waddr = ix(r_bp - tag_rd - 32'd4);  mem.wdata = r_size;
                n_state = S_MB11;
            end
            S_MB11: begin
                mem.raddr = ix(r_bp - 32'd4);  n_state = S_MB12;
            end
            S_MB12: begin
                n_t = r_bp + tag_rd;  mem.raddr = ix(r_bp + tag_rd - 32'd4);
                n_state = S_MB13;
            end
            S_MB13: begin
                mem.we = 1'b1;  mem.waddr = ix(r_t + tag_rd - 32'd8);  mem.wdata = r_size;
                n_state = S_MN9;
            end
            // extend the heap top by r_asize
            S_G0: begin
                if ({14'd0, r_top} + {1'b0, r_asize} > HEAP_BYTES) begin
                    n_res = '0;  n_null = 1'b1;  n_state = r_ret_a;
                end else begin
                    mem.we = 1'b1;  mem.waddr = ix(top32 - 32'd4);  mem.wdata = r_asize;
                    n_state = S_G1;
                end
            end
            S_G1: begin
                mem.we = 1'b1;  mem.waddr = ix(top32 + r_asize - 32'd8);  mem.wdata = r_asize;
                n_state = S_G2;
            end
            S_G2: begin
                mem.we = 1'b1;  mem.waddr = ix(top32 + r_asize - 32'd4);  mem.wdata = 32'd1;
                n_top = r_top + r_asize[18:0];
                n_bp = top32;  n_ret_m = S_G3;  n_state = S_M0;
            end
            S_G3: begin
                if (r_bp == '0) begin
                    n_res = '0;  n_null = 1'b1;  n_state = r_ret_a;
                end else begin
                    n_state = S_C0;
                end
            end
            // first fit from the request class upward
            S_A0: begin
                if (r_req == '0) begin
                    n_res = '0;  n_null = 1'b1;  n_state = r_ret_a;
                end else begin
                    n_asize = a_round;  n_steps = '0;  n_c = class_of(a_round);
                    n_state = S_F0;
                end
            end
            S_F0: begin
                mem.raddr = ix(root_of(r_c));  n_state = S_F1;
            end
            S_F1: begin
                if (i_mem_rdata == '0) begin
                    if (r_c == CLS_W'(NUM_CLASSES - 1)) begin
                        n_state = S_G0;
                    end else begin
                        n_c = r_c + 1'b1;  mem.raddr = ix(root_of(r_c + 1'b1));
                    end
                end else if (r_steps >= (HEAP_AW+1)'(HEAP_WORDS)) begin
                    n_state = S_G0;
                end else begin
                    n_steps = r_steps + 1'b1;  n_bp = i_mem_rdata;
                    mem.raddr = ix(i_mem_rdata - 32'd4);  n_state = S_F2;
                end
            end
            S_F2: begin
                if (r_asize <= tag_rd) begin
                    n_state = S_C0;
                end else begin
                    mem.raddr = ix(r_bp + 32'd4);  n_state = S_F1;
                end
            end
            // take the block, split off a free remainder of 16 bytes or more
            S_C0: begin
                n_lbp = r_bp;  n_ret_l = S_C1;  n_state = S_U0;
            end
            S_C1: begin
                mem.raddr = ix(r_bp - 32'd4);  n_state = S_C2;
            end
            S_C2: begin
                n_cs = tag_rd;  mem.we = 1'b1;  mem.waddr = ix(r_bp - 32'd4);
                if (tag_rd - r_asize >= 32'd16) begin
                    mem.wdata = r_asize | 32'd1;  n_state = S_C3;
                end else begin
                    mem.wdata = tag_rd | 32'd1;   n_state = S_C6;
                end
            end
            S_C3: begin
                mem.we = 1'b1;  mem.waddr = ix(r_bp + r_asize - 32'd8);
                mem.wdata = r_asize | 32'd1;  n_state = S_C4;
            end
            S_C4: begin
                mem.we = 1'b1;  mem.waddr = ix(r_bp + r_asize - 32'd4);
                mem.wdata = r_cs - r_asize;  n_state = S_C5;
            end
            S_C5: begin
                mem.we = 1'b1;  mem.waddr = ix(r_bp + r_cs - 32'd8);
                mem.wdata = r_cs - r_asize;
                n_lbp = r_bp + r_asize;  n_ret_l = S_C7;  n_state = S_L0;
            end
            S_C6: begin
                mem.we = 1'b1;  mem.waddr = ix(r_bp + r_cs - 32'd8);
                mem.wdata = r_cs | 32'd1;  n_state = S_C7;
            end
            S_C7: begin
                n_res = r_bp;  n_null = 1'b0;  n_state = r_ret_a;
            end
            // free r_ptr
            S_FR0: begin
                if (r_ptr == '0) begin
                    n_state = r_ret_f;
                end else begin
                    mem.raddr = ix(r_ptr - 32'd4);  n_state = S_FR1;
                end
            end
            S_FR1: begin
                n_t = tag_rd;
                mem.we = 1'b1;  mem.waddr = ix(r_ptr - 32'd4);  mem.wdata = tag_rd;
                n_state = S_FR2;
            end
            S_FR2: begin
                mem.we = 1'b1;  mem.waddr = ix(r_ptr + r_t - 32'd8);  mem.wdata = r_t;
                n_bp = r_ptr;  n_ret_m = r_ret_f;  n_state = S_M0;
            end
            // realloc
            S_R0: begin
                if (r_req == '0) begin
                    n_null = 1'b1;  n_state = S_DONE;
                end else if (r_ptr == '0) begin
                    n_ret_a = S_DONE;  n_state = S_A0;
                end else begin
                    n_asize = a_round;  mem.raddr = ix(r_ptr - 32'd4);  n_state = S_R1;
                end
            end
            S_R1: begin
                n_old = tag_rd;
                if (r_asize <= tag_rd) begin
                    n_res = r_ptr;  n_state = S_DONE;
                end else begin
                    n_t = r_ptr + tag_rd;  mem.raddr = ix(r_ptr + tag_rd - 32'd4);
                    n_state = S_R2;
                end
            end
            S_R2: begin
                if (!i_mem_rdata[0] &&
                    ({1'b0, tag_rd} + {1'b0, r_old} >= {1'b0, r_asize})) begin
                    n_lbp = r_t;  n_ret_l = S_R3;  n_state = S_U0;
                end else begin
                    n_ret_a = S_R6;  n_state = S_A0;
                end
            end
            S_R3: begin
                mem.raddr = ix(r_ptr - 32'd4);  n_state = S_R4;
            end
            S_R4: begin
                mem.raddr = ix(r_ptr + tag_rd - 32'd4);  n_state = S_R5;
            end
            S_R5: begin
                n_t = tag_rd + r_old;
                mem.we = 1'b1;  mem.waddr = ix(r_ptr - 32'd4);
                mem.wdata = (tag_rd + r_old) | 32'd1;  n_state = S_R5B;
            end
            S_R5B: begin
                mem.we = 1'b1;  mem.waddr = ix(r_ptr + r_t - 32'd8);  mem.wdata = r_t | 32'd1;
                n_res = r_ptr;  n_state = S_DONE;
            end
            S_R6: begin
                if (r_null) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = (r_old[31:2] > 30'(HEAP_WORDS)) ? (HEAP_AW+1)'(HEAP_WORDS)
                                                             : r_old[HEAP_AW+2:2];
                    n_idx = '0;  n_state = S_K0;
                end
            end
            // word copy, read then write so overlapping blocks behave
            S_K0: begin
                if (r_idx == r_cnt) begin
                    n_ret_f = S_DONE;  n_state = S_FR0;
                end else begin
                    mem.raddr = ix(r_ptr + idx4);  n_state = S_K1;
                end
            end
            S_K1: begin
                mem.we = 1'b1;  mem.waddr = ix(r_res + idx4);  mem.wdata = i_mem_rdata;
                n_idx = r_idx + 1'b1;  n_state = S_K0;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_top   <= 19'(INIT_TOP);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_top   <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret_l <= n_ret_l;  r_ret_m <= n_ret_m;  r_ret_a <= n_ret_a;  r_ret_f <= n_ret_f;
        r_cmd   <= n_cmd;    r_addr  <= n_addr;   r_req   <= n_req;    r_wdata <= n_wdata;
        r_asize <= n_asize;  r_bp    <= n_bp;     r_lbp   <= n_lbp;    r_root  <= n_root;
        r_succ  <= n_succ;   r_pred  <= n_pred;   r_head  <= n_head;   r_t     <= n_t;
        r_size  <= n_size;   r_cs    <= n_cs;     r_ptr   <= n_ptr;    r_old   <= n_old;
        r_res   <= n_res;    r_rdout <= n_rdout;  r_pa    <= n_pa;     r_na    <= n_na;
        r_null  <= n_null;   r_cnt   <= n_cnt;    r_idx   <= n_idx;    r_steps <= n_steps;
        r_c     <= n_c;
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_mem        = mem;
    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.addr   = r_res[17:0];
    assign o_res.rdata  = r_rdout;
    assign o_res.status = r_null;

endmodule

@@ design/segregated_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// segregated_fit_heap_allocator
// Boundary-tag heap allocator with segregated free lists in a 64k word RAM.
// ----------------------------------------------------------------------------
// Usage: one command word enters on the s_axis channel (tuser = command,
// tdata = addr, size, write data) and exactly one result word leaves on
// m_axis (tdata = result address, read data; tuser = null status).
// Commands are malloc, free, realloc, read word and write word.
// How long a command takes depends on the data, as every RAM access goes
// through the single read and single write port of the heap RAM. Free
// depends on how many neighbours merge and does no RAM access for a null
// pointer; malloc depends on how many free list entries and empty classes
// it passes over and on whether the heap must grow; realloc either keeps
// its block, absorbs the next block, or moves, and a move costs a malloc,
// a word by word copy of the old block and a free. One command is in work
// at a time. After reset the heap RAM is swept once, one word a cycle,
// loading the initial heap image; s_axis_tready stays low meanwhile.
// The finished result sits in an output register, so the next command is
// taken while it waits; if the receiver stalls, a second result holds the
// sequencer until the output register frees.
// ----------------------------------------------------------------------------
module segregated_fit_heap_allocator
    import sfha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // addr[17:0], size[35:18], write_data[67:36], zero pad
    input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // result_addr[17:0], read_data[49:18], zero pad
    output logic [0:0]  m_axis_tuser    // status[0]
);

    logic        idle, take, start;
    t_result     res;
    t_mem_req    mem;
    logic [31:0] mem_rdata;

    logic        r_ovalid;
    logic [17:0] r_oaddr;
    logic [31:0] r_odata;
    logic        r_ostat;

    assign s_axis_tready = idle;
    assign start = s_axis_tvalid & idle;
    assign take  = res.valid & (~r_ovalid | m_axis_tready);

    sfha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (s_axis_tuser),
        .i_addr      (s_axis_tdata[17:0]),
        .i_size      (s_axis_tdata[35:18]),
        .i_wdata     (s_axis_tdata[67:36]),
        .o_idle      (idle),
        .o_res       (res),
        .i_res_take  (take),
        .o_mem       (mem),
        .i_mem_rdata (mem_rdata)
    );

    sfha_ram #(
        .DEPTH (HEAP_WORDS),
        .WIDTH (32)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (take) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_oaddr <= res.addr;
            r_odata <= res.rdata;
            r_ostat <= res.status;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_odata, r_oaddr};
    assign m_axis_tuser  = r_ostat;

endmodule

@@ sim/sfha_checker.sv @@
// ----------------------------------------------------------------------------
// sfha_checker
// Watches both stream channels of the heap allocator, keeps its own image of
// the heap and the free lists, predicts the result word of every accepted
// command and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module sfha_checker
    import sfha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [71:0] i_cmd_data,    // addr[17:0], size[35:18], write_data[67:36], zero pad
    input  logic [2:0]  i_cmd_user,    // cmd[2:0]
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [55:0] i_res_data,    // result_addr[17:0], read_data[49:18], zero pad
    input  logic [0:0]  i_res_user,    // status[0]
    output int          o_fail_count,
    output int          o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [17:0] res_addr;
        logic [31:0] rdata;
        logic        status;
    } t_answer;

    logic [31:0] heap_img [HEAP_WORDS];
    logic [31:0] brk;
    t_answer     answers [$];

    function automatic logic [31:0] peek(input logic [31:0] a);
        return heap_img[a[HEAP_AW+1:2]];
    endfunction

    function automatic void poke(input logic [31:0] a, input logic [31:0] v);
        heap_img[a[HEAP_AW+1:2]] = v;
    endfunction

    function automatic logic [31:0] tag_sz(input logic [31:0] a);
        return peek(a) & ~32'd7;
    endfunction

    function automatic logic [31:0] blk_sz(input logic [31:0] bp);
        return tag_sz(bp - 32'd4);
    endfunction

    function automatic logic [31:0] foot(input logic [31:0] bp);
        return bp + blk_sz(bp) - 32'd8;
    endfunction

    function automatic logic [31:0] nxt(input logic [31:0] bp);
        return bp + blk_sz(bp);
    endfunction

    function automatic logic [31:0] prv(input logic [31:0] bp);
        return bp - tag_sz(bp - 32'd8);
    endfunction

    function automatic logic [31:0] bin_root(input logic [31:0] sz);
        logic [31:0] lim;
        int          c;
        lim = 32'd16;
        c = NUM_CLASSES - 1;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (sz <= lim) begin
                c = k;
                break;
            end
            lim = lim << 1;
        end
        return 32'(ROOT_BASE) + 32'(4 * c);
    endfunction

    function automatic void detach(input logic [31:0] bp);
        logic [31:0] r, succ, pred;
        r = bin_root(blk_sz(bp));
        succ = peek(bp + 32'd4);
        if (bp == peek(r)) begin
            poke(r, succ);
        end else begin
            pred = peek(bp);
            poke(pred + 32'd4, succ);
            if (succ != 0) poke(succ, pred);
        end
    endfunction

    function automatic void attach(input logic [31:0] bp);
        logic [31:0] r, head;
        r = bin_root(blk_sz(bp));
        head = peek(r);
        poke(bp + 32'd4, head);
        if (head != 0) poke(head, bp);
        poke(r, bp);
    endfunction

    function automatic logic [31:0] coalesce(input logic [31:0] bp);
        logic        pa, na;
        logic [31:0] sz;
        pa = |(peek(foot(prv(bp))) & 32'd1);
        na = |(peek(nxt(bp) - 32'd4) & 32'd1);
        sz = blk_sz(bp);
        if (pa && na) begin
            attach(bp);
            return bp;
        end
        if (pa) begin
            detach(nxt(bp));
            sz = sz + blk_sz(nxt(bp));
            poke(bp - 32'd4, sz);
            poke(foot(bp), sz);
        end else if (na) begin
            detach(prv(bp));
            sz = sz + blk_sz(prv(bp));
            poke(prv(bp) - 32'd4, sz);
            poke(foot(bp), sz);
            bp = prv(bp);
        end else begin
            detach(prv(bp));
            detach(nxt(bp));
            sz = sz + blk_sz(prv(bp)) + tag_sz(foot(nxt(bp)));
            poke(prv(bp) - 32'd4, sz);
            poke(foot(nxt(bp)), sz);
            bp = prv(bp);
        end
        attach(bp);
        return bp;
    endfunction

    function automatic logic [31:0] extend(input logic [31:0] sz);
        logic [31:0] bp;
        if ({1'b0, brk} + {1'b0, sz} > HEAP_BYTES) return 32'd0;
        bp = brk;
        poke(bp - 32'd4, sz);
        poke(foot(bp), sz);
        poke(nxt(bp) - 32'd4, 32'd1);
        brk = brk + sz;
        return coalesce(bp);
    endfunction

    function automatic logic [31:0] scan_bins(input logic [31:0] asz);
        logic [31:0] bp, steps, r;
        steps = 0;
        for (r = bin_root(asz); r < 32'(ROOT_BASE + 4 * NUM_CLASSES); r += 4) begin
            bp = peek(r);
            while (bp != 0) begin
                if (steps >= HEAP_WORDS) return 32'd0;
                steps++;
                if (asz <= blk_sz(bp)) return bp;
                bp = peek(bp + 32'd4);
            end
        end
        return 32'd0;
    endfunction

    function automatic void split_off(input logic [31:0] bp, input logic [31:0] asz);
        logic [31:0] csz;
        detach(bp);
        csz = blk_sz(bp);
        if (csz - asz >= 32'd16) begin
            poke(bp - 32'd4, asz | 32'd1);
            poke(foot(bp), asz | 32'd1);
            bp = nxt(bp);
            poke(bp - 32'd4, csz - asz);
            poke(foot(bp), csz - asz);
            attach(bp);
        end else begin
            poke(bp - 32'd4, csz | 32'd1);
            poke(foot(bp), csz | 32'd1);
        end
    endfunction

    function automatic logic [31:0] padded(input logic [31:0] sz);
        return (sz <= 32'd8) ? 32'd16 : 32'd8 * ((sz + 32'd15) / 32'd8);
    endfunction

    function automatic logic [31:0] heap_alloc(input logic [31:0] sz);
        logic [31:0] a, bp;
        if (sz == 0) return 32'd0;
        a = padded(sz);
        bp = scan_bins(a);
        if (bp == 0) begin
            bp = extend(a);
            if (bp == 0) return 32'd0;
        end
        split_off(bp, a);
        return bp;
    endfunction

    function automatic void heap_release(input logic [31:0] bp);
        logic [31:0] s;
        if (bp == 0) return;
        s = blk_sz(bp);
        poke(bp - 32'd4, s);
        poke(foot(bp), s);
        void'(coalesce(bp));
    endfunction

    function automatic logic [31:0] heap_resize(input logic [31:0] ptr, input logic [31:0] sz);
        logic [31:0] a, old, n, np, words, s;
        if (sz == 0) return 32'd0;
        if (ptr == 0) return heap_alloc(sz);
        a = padded(sz);
        old = blk_sz(ptr);
        if (a <= old) return ptr;
        n = nxt(ptr);
        if (((peek(n - 32'd4) & 32'd1) == 32'd0) &&
            {1'b0, blk_sz(n)} + {1'b0, old} >= {1'b0, a}) begin
            detach(n);
            s = blk_sz(nxt(ptr)) + old;
            poke(ptr - 32'd4, s | 32'd1);
            poke(foot(ptr), s | 32'd1);
            return ptr;
        end
        np = heap_alloc(sz);
        if (np == 0) return 32'd0;
        words = old / 32'd4;
        if (words > HEAP_WORDS) words = HEAP_WORDS;
        for (logic [31:0] i = 0; i < words; i++) begin
            poke(np + 32'd4 * i, peek(ptr + 32'd4 * i));
        end
        heap_release(ptr);
        return np;
    endfunction

    initial begin
        foreach (heap_img[i]) heap_img[i] = 32'd0;
        poke(32'd4, 32'(PRO_WORDS * 4 + 1));
        poke(32'(4 * PRO_WORDS), 32'(PRO_WORDS * 4 + 1));
        poke(32'(4 * (PRO_WORDS + 1)), 32'd1);
        brk = 32'((PRO_WORDS + 2) * 4);
        void'(extend(32'd16));
        o_fail_count = 0;
        o_waiting = 0;
    end

    always @(posedge i_clk) begin
        logic [2:0]  op;
        logic [31:0] a, sz, wd, ra;
        t_answer     exp_w;
        int          errs;
        errs = 0;
        if (i_rst_n && i_cmd_valid && i_cmd_ready) begin
            op = i_cmd_user;
            a  = 32'(i_cmd_data[17:0]);
            sz = 32'(i_cmd_data[35:18]);
            wd = i_cmd_data[67:36];
            ra = 0;
            exp_w = '{res_addr: '0, rdata: '0, status: 1'b0};
            case (op)
                CMD_MALLOC: begin
                    ra = heap_alloc(sz);
                    exp_w.status = (ra == 0);
                end
                CMD_FREE: heap_release(a);
                CMD_REALLOC: begin
                    ra = heap_resize(a, sz);
                    exp_w.status = (ra == 0);
                end
                CMD_READ:  exp_w.rdata = peek(a);
                CMD_WRITE: poke(a, wd);
                default: ;
            endcase
            exp_w.res_addr = ra[17:0];
            answers.push_back(exp_w);
        end
        if (i_rst_n && i_res_valid && i_res_ready) begin
            if (answers.size() == 0) begin
                $error("result word with nothing outstanding: %h", i_res_data);
                errs++;
            end else begin
                exp_w = answers.pop_front();
                if (i_res_data[17:0] !== exp_w.res_addr) begin
                    $error("result_addr expected %h got %h", exp_w.res_addr, i_res_data[17:0]);
                    errs++;
                end
                if (i_res_data[49:18] !== exp_w.rdata) begin
                    $error("read_data expected %h got %h", exp_w.rdata, i_res_data[49:18]);
                    errs++;
                end
                if (i_res_user[0] !== exp_w.status) begin
                    $error("status expected %b got %b", exp_w.status, i_res_user[0]);
                    errs++;
                end
            end
        end
        if (errs != 0) o_fail_count <= o_fail_count + errs;
        o_waiting <= answers.size();
    end

endmodule

@@ sim/tb_segregated_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_segregated_fit_heap_allocator
// Drives malloc, free, realloc and word access commands into the allocator,
// mostly on blocks it actually owns, under varying stall patterns, and leaves
// prediction and comparison to the checker instance.
// ----------------------------------------------------------------------------
module tb_segregated_fit_heap_allocator;
    import sfha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_LAST_DEFINED = CMD_WRITE;
    localparam int         N_RANDOM         = 500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // addr[17:0], size[35:18], write_data[67:36], zero pad
    logic [2:0]  s_axis_tuser = '0;   // cmd[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // result_addr[17:0], read_data[49:18], zero pad
    logic [0:0]  m_axis_tuser;        // status[0]

    int fail_count, waiting;

    typedef struct {
        logic [2:0]  op;
        logic [17:0] ptr;
        int unsigned old_len;
        int unsigned new_len;
    } t_issued;

    t_issued     in_flight [$];
    logic [17:0] owned_ptr [$];
    int unsigned owned_len [$];

    int unsigned words_taken = 0;
    int          send_idle_pct = 0;
    int          sink_stall_pct = 0;
    bit          want_hold = 0;
    bit          hold_done = 0;
    int          hold_left = 0;

    segregated_fit_heap_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sfha_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (s_axis_tvalid),
        .i_cmd_ready  (s_axis_tready),
        .i_cmd_data   (s_axis_tdata),
        .i_cmd_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[segregated_fit_heap_allocator] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) words_taken <= words_taken + 1;
    end

    // track which blocks the allocator has handed out
    always @(posedge i_clk) begin
        t_issued t;
        if (i_rst_n && m_axis_tvalid && m_axis_tready && in_flight.size() != 0) begin
            t = in_flight.pop_front();
            if ((t.op == CMD_MALLOC || t.op == CMD_REALLOC) && !m_axis_tuser[0]) begin
                owned_ptr.push_back(m_axis_tdata[17:0]);
                owned_len.push_back(t.new_len);
            end else if (t.op == CMD_REALLOC && t.ptr != 0) begin
                owned_ptr.push_back(t.ptr);
                owned_len.push_back(t.old_len);
            end
        end
    end

    // receiver side, with one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (want_hold && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send(input logic [2:0] op, input logic [17:0] a, input logic [17:0] sz,
                        input logic [31:0] wd, input int unsigned old_len = 0);
        int unsigned target;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, wd, sz, a};
        target = words_taken + 1;
        do @(negedge i_clk); while (words_taken != target);
        in_flight.push_back('{op: op, ptr: a, old_len: old_len, new_len: int'(sz)});
    endtask

    // drop the request first so the last word is not taken a second time
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (in_flight.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [17:0] word_in(input int idx);
        return owned_ptr[idx] + 18'(4 * $urandom_range(0, (owned_len[idx] + 3) / 4 - 1));
    endfunction

    task automatic random_command();
        int          r, idx;
        logic [17:0] p, sz;
        int unsigned ln;
        r = $urandom_range(99);
        if (owned_ptr.size() == 0 && r >= 30) r = 0;
        if (owned_ptr.size() > 40 && r < 30) r = 30;
        if (r < 30) begin
            if ($urandom_range(99) < 85) sz = 18'($urandom_range(1, 120));
            else if ($urandom_range(9) == 0) sz = 18'($urandom);
            else sz = 18'($urandom_range(1, 3000));
            send(CMD_MALLOC, 18'($urandom), sz, $urandom);
        end else if (r < 50 || r < 65) begin
            idx = $urandom_range(0, owned_ptr.size() - 1);
            p = owned_ptr[idx];
            ln = owned_len[idx];
            owned_ptr.delete(idx);
            owned_len.delete(idx);
            if (r < 50) begin
                send(CMD_FREE, p, 18'($urandom), $urandom);
            end else begin
                sz = ($urandom_range(19) == 0) ? 18'd0 : 18'($urandom_range(1, 300));
                send(CMD_REALLOC, p, sz, $urandom, ln);
            end
        end else if (r < 80) begin
            idx = $urandom_range(0, owned_ptr.size() - 1);
            send(CMD_WRITE, word_in(idx), 18'($urandom), $urandom);
        end else if (r < 95) begin
            idx = $urandom_range(0, owned_ptr.size() - 1);
            send(CMD_READ, word_in(idx), 18'($urandom), $urandom);
        end else begin
            case ($urandom_range(3))
                0: send(3'($urandom_range(CMD_LAST_DEFINED + 1, 7)), 18'($urandom),
                        18'($urandom), $urandom);
                1: send(CMD_READ, 18'($urandom), 18'($urandom), $urandom);
                2: send(CMD_MALLOC, 18'($urandom), 18'd0, $urandom);
                default: send(CMD_FREE, 18'd0, 18'($urandom), $urandom);
            endcase
        end
    endtask

    initial begin
        int idx;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero size, smallest sizes, heap exhausted, realloc of null
        send(CMD_MALLOC, 18'd0, 18'd0, 32'd0);
        send(CMD_MALLOC, 18'd0, 18'd1, 32'd0);
        send(CMD_MALLOC, 18'd0, 18'd8, 32'd0);
        send(CMD_MALLOC, 18'd0, 18'd9, 32'd0);
        send(CMD_MALLOC, 18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF);
        send(CMD_MALLOC, 18'd0, 18'd16, 32'd0);
        send(CMD_REALLOC, 18'd0, 18'd24, 32'd0);
        settle();
        send(CMD_WRITE, owned_ptr[0], 18'd0, 32'hFFFF_FFFF);
        send(CMD_READ, owned_ptr[0], 18'd0, 32'd0);
        send(CMD_WRITE, owned_ptr[1], 18'd0, 32'hA5A5_5A5A);
        send(CMD_WRITE, owned_ptr[0], 18'd0, 32'd0);
        send(CMD_READ, owned_ptr[0], 18'd0, 32'd0);
        // realloc: keep in place, grow (moves with copy), zero size keeps
        send(CMD_REALLOC, owned_ptr[2], 18'd4, 32'd0, owned_len[2]);
        send(CMD_REALLOC, owned_ptr[1], 18'd200, 32'd0, owned_len[1]);
        send(CMD_REALLOC, owned_ptr[3], 18'd0, 32'd0, owned_len[3]);
        owned_ptr = owned_ptr[4:$];
        owned_len = owned_len[4:$];
        // neighbours freed in turn so that merging hits both sides
        while (owned_ptr.size() > 1) begin
            send(CMD_FREE, owned_ptr[0], 18'd0, 32'd0);
            owned_ptr.delete(0);
            owned_len.delete(0);
        end
        send(CMD_FREE, 18'd0, 18'h3FFFF, 32'hFFFF_FFFF);
        for (int c = CMD_LAST_DEFINED + 1; c <= 7; c++) begin
            send(3'(c), 18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF);
        end
        send(CMD_READ, 18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 66; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 66; end
                default: begin send_idle_pct = 9; sink_stall_pct = 9; end
            endcase
            if (ph == 1) begin
                send_idle_pct = 0;
                want_hold = 1'b1;
                repeat (30) random_command();
                send_idle_pct = 66;
            end
            repeat (N_RANDOM / 4) random_command();
        end

        // finally a free of an arbitrary address; tags are taken as found
        settle();
        send(CMD_FREE, 18'($urandom), 18'($urandom), $urandom);
        settle();
        repeat (200) @(negedge i_clk);

        if (fail_count == 0 && waiting == 0) begin
            $display("[segregated_fit_heap_allocator] OK");
        end else begin
            $display("[segregated_fit_heap_allocator] ERROR");
        end
        $finish;
    end

endmodule
